FILE: rtl/core/modexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, register indexes, datapath command and status types.
// ----------------------------------------------------------------------------
package modexp_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_BITS  = $clog2(WORD_BITS);

    // Register indexes
    localparam logic REG_MODULUS  = 1'b0;
    localparam logic REG_EXPONENT = 1'b1;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,     // latch message, set acc to 1 mod n
        OP_REDUCE,   // one restoring step of base mod n
        OP_MUL_SQR,  // start acc * acc
        OP_MUL_BASE, // start acc * base
        OP_MUL_STEP, // one shift-and-add step
        OP_MUL_DONE  // write product to acc
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [CNT_BITS-1:0] bit_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic mod_zero;
    } dp_stat_t;

endpackage

FILE: rtl/core/modexp_datapath.sv
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Base reduction, serial modular multiplier and accumulator.
// ----------------------------------------------------------------------------
module modexp_datapath (
    input  logic                                clk,
    input  logic [modexp_pkg::WORD_BITS-1:0]    modulus,
    input  logic [modexp_pkg::WORD_BITS-1:0]    message,
    input  modexp_pkg::dp_cmd_t                 cmd,
    output modexp_pkg::dp_stat_t                stat,
    output logic [modexp_pkg::WORD_BITS-1:0]    acc
);

    localparam int W = modexp_pkg::WORD_BITS;

    logic [W-1:0]   base_reg, base_next;
    logic [W-1:0]   acc_reg, acc_next;
    logic [W-1:0]   mcand_reg, mcand_next;
    logic [W-1:0]   mplier_reg, mplier_next;
    logic [W-1:0]   prod_reg, prod_next;
    logic [W-1:0]   rem_reg, rem_next;
    logic [2*W-1:0] wrap_prod;
    logic [W:0]     dbl, dbl_red, add_sum;
    logic [W-1:0]   dbl_mod;
    logic [W:0]     rem_sh;

    assign stat.mod_zero = (modulus == '0);
    assign acc           = acc_reg;

    // product modulo 2^W when modulus is zero
    assign wrap_prod = mcand_reg * mplier_reg;

    // shift-and-add step: r = 2r mod n, then + a mod n when the multiplier bit is set
    assign dbl     = {prod_reg, 1'b0};
    assign dbl_red = dbl - {1'b0, modulus};
    assign dbl_mod = (dbl >= {1'b0, modulus}) ? dbl_red[W-1:0] : dbl[W-1:0];
    assign add_sum = {1'b0, dbl_mod} + {1'b0, mcand_reg};

    // restoring remainder step for base mod n; message held in mplier
    assign rem_sh = {rem_reg, mplier_reg[cmd.bit_idx]};

    always_comb
    begin
        base_next   = base_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        case (cmd.op)
            modexp_pkg::OP_LOAD:
            begin
                rem_next    = '0;
                acc_next    = (modulus == W'(1)) ? '0 : W'(1);
                base_next   = message;
                mplier_next = message;
            end
            modexp_pkg::OP_REDUCE:
            begin
                if (rem_sh >= {1'b0, modulus})
                    rem_next = W'(rem_sh - {1'b0, modulus});
                else
                    rem_next = rem_sh[W-1:0];
                base_next = (rem_sh >= {1'b0, modulus}) ?
                            W'(rem_sh - {1'b0, modulus}) : rem_sh[W-1:0];
            end
            modexp_pkg::OP_MUL_SQR:
            begin
                mcand_next  = acc_reg;
                mplier_next = acc_reg;
                prod_next   = '0;
            end
            modexp_pkg::OP_MUL_BASE:
            begin
                mcand_next  = acc_reg;
                mplier_next = base_reg;
                prod_next   = '0;
            end
            modexp_pkg::OP_MUL_STEP:
            begin
                if (mplier_reg[cmd.bit_idx])
                begin
                    if (add_sum >= {1'b0, modulus})
                        prod_next = W'(add_sum - {1'b0, modulus});
                    else
                        prod_next = add_sum[W-1:0];
                end
                else
                    prod_next = dbl_mod;
            end
            modexp_pkg::OP_MUL_DONE:
                acc_next = (modulus == '0) ? wrap_prod[W-1:0] : prod_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
    end

endmodule

FILE: rtl/core/modexp_ctrl.sv
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences base reduction and square-and-multiply over exponent bits.
// ----------------------------------------------------------------------------
module modexp_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    output logic                                out_valid,
    input  logic                                out_ready,
    input  logic [modexp_pkg::WORD_BITS-1:0]    exponent,
    input  modexp_pkg::dp_stat_t                stat,
    output modexp_pkg::dp_cmd_t                 cmd,
    output logic                                one_sel
);

    localparam int CB = modexp_pkg::CNT_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_REDUCE, S_SQR, S_MUL_SQR, S_CHK, S_MUL_BASE, S_FINISH, S_OUT
    } state_t;

    state_t          state_reg;
    logic [CB-1:0]   ebit_reg;
    logic [CB-1:0]   step_reg;
    logic            out_valid_reg;
    logic            one_reg;
    logic            cmd_from_base_reg;  // running multiply is by the base

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign one_sel   = one_reg;

    // datapath command decode
    always_comb
    begin
        cmd.op      = modexp_pkg::OP_NONE;
        cmd.bit_idx = step_reg;
        case (state_reg)
            S_IDLE:     if (in_valid && in_ready) cmd.op = modexp_pkg::OP_LOAD;
            S_REDUCE:   cmd.op = stat.mod_zero ? modexp_pkg::OP_NONE
                                               : modexp_pkg::OP_REDUCE;
            S_SQR:      cmd.op = modexp_pkg::OP_MUL_SQR;
            S_MUL_SQR,
            S_MUL_BASE: cmd.op = modexp_pkg::OP_MUL_STEP;
            S_CHK:      cmd.op = exponent[ebit_reg] ? modexp_pkg::OP_MUL_BASE
                                                    : modexp_pkg::OP_NONE;
            S_FINISH:   cmd.op = modexp_pkg::OP_MUL_DONE;
            default:    cmd.op = modexp_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            ebit_reg          <= '0;
            step_reg          <= '0;
            out_valid_reg     <= 1'b0;
            one_reg           <= 1'b0;
            cmd_from_base_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_valid && in_ready)
                    begin
                        one_reg  <= (exponent == '0);
                        step_reg <= CB'(modexp_pkg::WORD_BITS - 1);
                        ebit_reg <= CB'(modexp_pkg::WORD_BITS - 1);
                        state_reg <= (exponent == '0) ? S_OUT : S_REDUCE;
                    end
                S_REDUCE:
                begin
                    step_reg <= step_reg - CB'(1);
                    if (step_reg == '0)
                        state_reg <= S_SQR;
                end
                S_SQR:
                begin
                    cmd_from_base_reg <= 1'b0;
                    step_reg  <= CB'(modexp_pkg::WORD_BITS - 1);
                    state_reg <= S_MUL_SQR;
                end
                S_MUL_SQR:
                begin
                    step_reg <= step_reg - CB'(1);
                    if (step_reg == '0)
                        state_reg <= S_FINISH;
                end
                S_FINISH:
                    // after the base multiply the bit is done
                    if (!cmd_from_base_reg)
                        state_reg <= S_CHK;
                    else if (ebit_reg == '0)
                        state_reg <= S_OUT;
                    else
                    begin
                        ebit_reg  <= ebit_reg - CB'(1);
                        state_reg <= S_SQR;
                    end
                S_CHK:
                    if (exponent[ebit_reg])
                    begin
                        cmd_from_base_reg <= 1'b1;
                        step_reg  <= CB'(modexp_pkg::WORD_BITS - 1);
                        state_reg <= S_MUL_BASE;
                    end
                    else if (ebit_reg == '0)
                        state_reg <= S_OUT;
                    else
                    begin
                        ebit_reg  <= ebit_reg - CB'(1);
                        state_reg <= S_SQR;
                    end
                S_MUL_BASE:
                begin
                    step_reg <= step_reg - CB'(1);
                    if (step_reg == '0)
                        state_reg <= S_FINISH;
                end
                S_OUT:
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/modular_exponentiation_unit.sv
// A request runs through the bit-serial base reduction and the shift-and-add
//   multiplier, one bit a cycle. A zero exponent skips both: the result is 1.
// One request in flight; the next can be accepted from the cycle after the result is taken.
// Reset is asynchronous, active low; modulus resets to 1, exponent to 0.
// ----------------------------------------------------------------------------
// Modular exponentiation unit
// Raises each message to the configured exponent modulo the configured modulus.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [modexp_pkg::WORD_BITS-1:0]    cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [modexp_pkg::WORD_BITS-1:0]    message,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [modexp_pkg::WORD_BITS-1:0]    result
);

    localparam int W = modexp_pkg::WORD_BITS;

    logic [W-1:0]         modulus_reg, exponent_reg;
    logic [W-1:0]         acc;
    logic                 one_sel;
    modexp_pkg::dp_cmd_t  cmd;
    modexp_pkg::dp_stat_t stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= W'(1);
            exponent_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == modexp_pkg::REG_MODULUS)
                modulus_reg <= cfg_data;
            else if (cfg_index == modexp_pkg::REG_EXPONENT)
                exponent_reg <= cfg_data;
        end
    end

    modexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .exponent  (exponent_reg),
        .stat      (stat),
        .cmd       (cmd),
        .one_sel   (one_sel)
    );

    modexp_datapath u_dp (
        .clk     (clk),
        .modulus (modulus_reg),
        .message (message),
        .cmd     (cmd),
        .stat    (stat),
        .acc     (acc)
    );

    assign result = one_sel ? W'(1) : acc;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("accept while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result))
        else $error("result dropped");
`endif

endmodule
